FILE: rtl/indexed_list_engine_assert.svh
// Assertion macros for the indexed list engine.
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off during reset.
`define ILE_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i, off during reset.
`define ILE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ILE_ASSERT(lbl, ante, cons, msg)
`define ILE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/ile_pkg.sv
// Shared types and constants for the indexed list engine.
package ile_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned COUNT_W = 9;

  typedef enum logic [1:0] {
    REQ_APPEND  = 2'd0,
    REQ_PREPEND = 2'd1,
    REQ_INSERT  = 2'd2,
    REQ_REMOVE  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    req_type_e                  req_type;
    logic signed [WORD_W-1:0]   value;
    logic        [SLOT_W-1:0]   position;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]   removed_value;
    status_e                    status;
    logic        [COUNT_W-1:0]  entry_count;
  } rsp_t;

  // Broadcast from the controller to every cell in the chain.
  typedef struct packed {
    logic                       ins;
    logic                       rem;
    logic        [SLOT_W-1:0]   slot;
    logic signed [WORD_W-1:0]   value;
  } cell_bus_t;

endpackage

FILE: rtl/ile_cell.sv
// One slot of the list: holds a word and trades it with its neighbors.
module ile_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                             clk_i,
  input  ile_pkg::cell_bus_t               bus_i,
  input  logic signed [ile_pkg::WORD_W-1:0] left_i,
  input  logic signed [ile_pkg::WORD_W-1:0] right_i,
  output logic signed [ile_pkg::WORD_W-1:0] word_o,
  output logic signed [ile_pkg::WORD_W-1:0] tap_o
);

  localparam logic [ile_pkg::SLOT_W-1:0] MyIdx = ile_pkg::SLOT_W'(IDX);

  logic signed [ile_pkg::WORD_W-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (bus_i.ins) begin
      if (MyIdx > bus_i.slot) begin
        word_d = left_i;
      end else if (MyIdx == bus_i.slot) begin
        word_d = bus_i.value;
      end
    end else if (bus_i.rem && (MyIdx >= bus_i.slot)) begin
      word_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  // only the addressed cell drives its word onto the removal OR
  assign tap_o  = (MyIdx == bus_i.slot) ? word_q : '0;

endmodule

FILE: rtl/indexed_list_engine.sv
// Top level of the indexed list engine: controller, cell chain and result register.
//
//  channel   | ports                      | transfer
//  ----------+----------------------------+-----------------------------------
//  request   | start, busy, req_i         | start high and busy low at clk edge
//  result    | done_o, rsp_o              | done_o high for one cycle, no stall
//
// One request is taken per cycle; its result is registered and shows on rsp_o in the next cycle.
// Every cell compares its slot with the request slot and, in the same cycle,
// loads the new word, copies from its left or right neighbor, or keeps its word.
// busy stays low: the chain finishes each request in the cycle it arrives.
// Reset clears the count and the result strobe; the slots need no clearing,
// only slots below the count are ever read.
// The result side cannot stall, so nothing is ever held back.
`include "indexed_list_engine_assert.svh"

module indexed_list_engine #(
  parameter int unsigned DEPTH = ile_pkg::DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ile_pkg::req_t req_i,
  output logic          done_o,
  output ile_pkg::rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned W    = ile_pkg::WORD_W;
  localparam int unsigned CW   = ile_pkg::COUNT_W;

  logic [CntW-1:0] count_q, count_d;
  logic            done_q;
  ile_pkg::rsp_t   rsp_q, rsp_d;

  logic            accept, full, empty, is_rem;
  logic [CW-1:0]   pos_ext, cnt_ext, slot_ext;
  ile_pkg::cell_bus_t bus;

  logic signed [W-1:0] words [DEPTH];
  logic signed [W-1:0] taps  [DEPTH];
  logic signed [W-1:0] picked;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);
  assign is_rem = (req_i.req_type == ile_pkg::REQ_REMOVE);

  assign pos_ext = CW'(req_i.position);
  assign cnt_ext = CW'(count_q);

  // Clamp the request to a real slot; past the end means tail (or last on remove).
  always_comb begin
    slot_ext = pos_ext;
    case (req_i.req_type)
      ile_pkg::REQ_APPEND:  slot_ext = cnt_ext;
      ile_pkg::REQ_PREPEND: slot_ext = '0;
      ile_pkg::REQ_INSERT:  slot_ext = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;
      ile_pkg::REQ_REMOVE:  slot_ext = (pos_ext >= cnt_ext) ? (cnt_ext - CW'(1)) : pos_ext;
      default:              slot_ext = pos_ext;
    endcase
  end

  assign bus.ins   = accept && !is_rem && !full;
  assign bus.rem   = accept && is_rem && !empty;
  assign bus.slot  = slot_ext[ile_pkg::SLOT_W-1:0];
  assign bus.value = req_i.value;

  // Cell chain; the ends see their own word as the missing neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [W-1:0] left_w, right_w;
    if (i == 0) begin : g_head
      assign left_w = words[i];
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_w = words[i];
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    ile_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .bus_i   (bus),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (words[i]),
      .tap_o   (taps[i])
    );
  end

  // Only the addressed cell can have a nonzero tap.
  always_comb begin
    picked = '0;
    for (int i = 0; i < DEPTH; i++) begin
      picked = picked | taps[i];
    end
  end

  always_comb begin
    count_d             = count_q;
    rsp_d.removed_value = '0;
    rsp_d.status        = ile_pkg::ST_DONE;
    if (is_rem) begin
      if (empty) begin
        rsp_d.status = ile_pkg::ST_EMPTY;
      end else begin
        rsp_d.removed_value = picked;
        count_d             = count_q - CntW'(1);
      end
    end else begin
      if (full) begin
        rsp_d.status = ile_pkg::ST_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
    rsp_d.entry_count = CW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // ---------------------------------------------------------------------------
  `ILE_ASSERT(a_count_bound, 1'b1, count_q <= CntW'(DEPTH), "entry count above depth")
  `ILE_ASSERT_NEXT(a_done_follows, accept, done_o, "accepted request gave no result")
  `ILE_ASSERT_NEXT(a_full_keeps, accept && !is_rem && full, (rsp_o.status == ile_pkg::ST_FULL) && (count_q == $past(count_q)), "full insert changed the list")
  `ILE_ASSERT_NEXT(a_empty_zero, accept && is_rem && empty, (rsp_o.status == ile_pkg::ST_EMPTY) && (rsp_o.removed_value == '0), "empty remove not flagged")

endmodule
